// File: hw/rtl/tlpt_pkg.sv
// Shared constants and control types of the two-level page table with LRU.
package tlpt_pkg;

  // Fixed field widths of the ports
  localparam int PID_IN_W = 2;
  localparam int VA_W = 32;
  localparam int PA_W = 20;
  localparam int OFFSET_W = 12;
  localparam int CFG_W = 5;

  // Reset value of the first-level split
  localparam logic [CFG_W-1:0] FLB_RESET = 5'd10;

  // Defaults of the top-level parameters
  localparam int DEF_PROCESS_COUNT = 4;
  localparam int DEF_FRAME_BITS = 8;
  localparam int DEF_VIRT_ADDR_BITS = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic rd_map;
    logic decide;
    logic upd_a;
    logic upd_b;
    logic upd_c;
    logic load_out;
  } tlpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
  } tlpt_status_t;

endpackage

// File: hw/rtl/tlpt_ifs.sv
// Handshake channel interfaces for access, result and configuration items.
interface tlpt_in_if import tlpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PID_IN_W-1:0] process_id;
  logic [VA_W-1:0]     virtual_address;
  modport source (output valid, process_id, virtual_address, input ready);
  modport sink (input valid, process_id, virtual_address, output ready);
endinterface

interface tlpt_out_if import tlpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] physical_address;
  logic            page_hit;
  logic            frame_replaced;
  logic            level_one_created;
  modport source (output valid, physical_address, page_hit, frame_replaced,
                  level_one_created, input ready);
  modport sink (input valid, physical_address, page_hit, frame_replaced,
                level_one_created, output ready);
endinterface

interface tlpt_cfg_if import tlpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/tlpt_ctrl.sv
// Sequencer for the clearing pass and the per-item lookup and update steps.
module tlpt_ctrl import tlpt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  tlpt_status_t status,
  output tlpt_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_UPD_A  = 3'd4;
  localparam logic [2:0] ST_UPD_B  = 3'd5;
  localparam logic [2:0] ST_UPD_C  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Decode state into commands and the next state
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_map = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = ST_UPD_A;
      end
      ST_UPD_A: begin
        cmd.upd_a = 1'b1;
        state_nxt = ST_UPD_B;
      end
      ST_UPD_B: begin
        cmd.upd_b = 1'b1;
        state_nxt = ST_UPD_C;
      end
      ST_UPD_C: begin
        cmd.upd_c = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Hold the result until taken, reload on completion
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A completed item always shows up at the output
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");

  // The clearing pass runs once after reset only
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass reentered");

  // An accepted item starts its lookup in the next cycle
  a_accept_go: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_READ))
    else $error("accepted item did not start");

endmodule

// File: hw/rtl/tlpt_datapath.sv
// Page table, frame and LRU link memories with the lookup and update datapath.
module tlpt_datapath import tlpt_pkg::*; #(
  parameter int PROCESS_COUNT = DEF_PROCESS_COUNT,
  parameter int FRAME_BITS = DEF_FRAME_BITS,
  parameter int VIRT_ADDR_BITS = DEF_VIRT_ADDR_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlpt_cmd_t           cmd,
  output tlpt_status_t        status,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [PID_IN_W-1:0] in_pid,
  input  logic [VA_W-1:0]     in_va,
  output logic [PA_W-1:0]     out_pa,
  output logic                out_hit,
  output logic                out_replaced,
  output logic                out_created
);

  localparam int VPN_W = VIRT_ADDR_BITS - OFFSET_W;
  localparam int PID_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int MAP_AW = PID_W + VPN_W;
  localparam int L1_W = VPN_W - 1;
  localparam int L1_AW = PID_W + L1_W;
  localparam int FB = FRAME_BITS;
  localparam int FRAMES = 1 << FB;
  localparam int CLR_W = (MAP_AW > FB) ? MAP_AW : FB;

  // Reduce a process number modulo the process count
  function automatic logic [PID_W-1:0] pid_reduce(input logic [PID_IN_W-1:0] p);
    logic [PID_IN_W-1:0] r;
    r = p;
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= PROCESS_COUNT) r = r - PID_IN_W'(PROCESS_COUNT);
    end
    return PID_W'(r);
  endfunction

  logic [CFG_W-1:0]    flb_r;
  logic [CLR_W-1:0]    clr_cnt_r;
  logic [PID_W-1:0]    pid_r;
  logic [VPN_W-1:0]    vpn_r;
  logic [OFFSET_W-1:0] off_r;
  logic [L1_W-1:0]     l1_r;
  logic [FB-1:0]       frame_r, oldest_r, newest_r;
  logic                hit_r, replaced_r, created_r, splice_r;
  logic [PA_W-1:0]     pa_r;
  logic                pa_hit_r, pa_rep_r, pa_cre_r;

  logic [FB:0]         map_mem [2**MAP_AW];
  logic                l1v_mem [2**L1_AW];
  logic                use_mem [FRAMES];
  logic [MAP_AW-1:0]   own_mem [FRAMES];
  logic [FB-1:0]       nwr_mem [FRAMES];
  logic [FB-1:0]       old_mem [FRAMES];

  logic [FB:0]         map_q;
  logic                l1v_q, use_q;
  logic [MAP_AW-1:0]   own_q;
  logic [FB-1:0]       nwr_q, old_q;

  // Split the page number with the saturated first-level width
  logic [VPN_W-1:0] in_vpn;
  logic [CFG_W-1:0] flb_sat;
  logic [5:0]       l1_shift;
  logic [VPN_W-1:0] l1_full;
  always_comb begin
    in_vpn = in_va[OFFSET_W +: VPN_W];
    flb_sat = (flb_r > CFG_W'(VPN_W - 1)) ? CFG_W'(VPN_W - 1) : flb_r;
    l1_shift = 6'(VPN_W) - {1'b0, flb_sat};
    l1_full = in_vpn >> l1_shift;
  end

  // Take the frame from the map on a hit, else the oldest frame
  logic          hit_now;
  logic [FB-1:0] frame_sel;
  logic          is_oldest, is_newest;
  always_comb begin
    hit_now = map_q[FB];
    frame_sel = hit_now ? map_q[FB-1:0] : oldest_r;
    is_oldest = (frame_r == oldest_r);
    is_newest = (frame_r == newest_r);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) flb_r <= FLB_RESET;
    else if (cfg_we) flb_r <= cfg_data;
  end

  // Clearing counter and LRU ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      oldest_r <= '0;
      newest_r <= '1;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.upd_a && (!hit_r || is_oldest)) oldest_r <= nwr_q;
      if (cmd.upd_c) newest_r <= frame_r;
    end
  end

  assign status.clr_last = (clr_cnt_r == '1);

  // Latch the item and its per-step results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pid_r <= pid_reduce(in_pid);
      vpn_r <= in_vpn;
      off_r <= in_va[OFFSET_W-1:0];
      l1_r <= l1_full[L1_W-1:0];
    end
    if (cmd.decide) begin
      hit_r <= hit_now;
      frame_r <= frame_sel;
      created_r <= !l1v_q;
    end
    if (cmd.upd_a) begin
      replaced_r <= !hit_r && use_q;
      splice_r <= hit_r && !is_oldest && !is_newest;
    end
    if (cmd.load_out) begin
      pa_r <= PA_W'({frame_r, off_r});
      pa_hit_r <= hit_r;
      pa_rep_r <= replaced_r;
      pa_cre_r <= created_r;
    end
  end

  // Page map: clear, evict the old owner, map the new page
  always_ff @(posedge clk) begin
    if (cmd.clr_step) map_mem[clr_cnt_r[MAP_AW-1:0]] <= '0;
    else if (cmd.upd_a && !hit_r && use_q) map_mem[own_q] <= {1'b0, frame_r};
    else if (cmd.upd_b && !hit_r) map_mem[{pid_r, vpn_r}] <= {1'b1, frame_r};
    if (cmd.rd_map) map_q <= map_mem[{pid_r, vpn_r}];
  end

  // First-level valid bits
  always_ff @(posedge clk) begin
    if (cmd.clr_step) l1v_mem[clr_cnt_r[L1_AW-1:0]] <= 1'b0;
    else if (cmd.decide) l1v_mem[{pid_r, l1_r}] <= 1'b1;
    if (cmd.rd_map) l1v_q <= l1v_mem[{pid_r, l1_r}];
  end

  // Frame in-use bits and owners
  always_ff @(posedge clk) begin
    if (cmd.clr_step) use_mem[clr_cnt_r[FB-1:0]] <= 1'b0;
    else if (cmd.upd_b && !hit_r) use_mem[frame_r] <= 1'b1;
    if (cmd.decide) use_q <= use_mem[frame_sel];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_b && !hit_r) own_mem[frame_r] <= {pid_r, vpn_r};
    if (cmd.decide) own_q <= own_mem[frame_sel];
  end

  // Newer links: ring init, unlink, link before oldest, append after newest
  always_ff @(posedge clk) begin
    if (cmd.clr_step) nwr_mem[clr_cnt_r[FB-1:0]] <= clr_cnt_r[FB-1:0] + 1'b1;
    else if (cmd.upd_a && hit_r && !is_oldest && !is_newest) nwr_mem[old_q] <= nwr_q;
    else if (cmd.upd_b && splice_r) nwr_mem[frame_r] <= oldest_r;
    else if (cmd.upd_c && splice_r) nwr_mem[newest_r] <= frame_r;
    if (cmd.decide) nwr_q <= nwr_mem[frame_sel];
  end

  // Older links, mirrored
  always_ff @(posedge clk) begin
    if (cmd.clr_step) old_mem[clr_cnt_r[FB-1:0]] <= clr_cnt_r[FB-1:0] - 1'b1;
    else if (cmd.upd_a && hit_r && !is_oldest && !is_newest) old_mem[nwr_q] <= old_q;
    else if (cmd.upd_b && splice_r) old_mem[frame_r] <= newest_r;
    else if (cmd.upd_c && splice_r) old_mem[oldest_r] <= frame_r;
    if (cmd.decide) old_q <= old_mem[frame_sel];
  end

  assign out_pa = pa_r;
  assign out_hit = pa_hit_r;
  assign out_replaced = pa_rep_r;
  assign out_created = pa_cre_r;

endmodule

// File: hw/rtl/two_level_page_table_lru.sv
// Top level of the two-level page table with LRU frame replacement.
//
//   channel   dir  handshake          carries
//   in_ch     in   valid/ready        process_id, virtual_address
//   out_ch    out  valid/ready        physical_address, page_hit,
//                                     frame_replaced, level_one_created
//   cfg_ch    in   valid/ready        first-level split width (5 bits)
//
// One item at a time, set by the single port of each memory: an accepted item
// passes read, decide, three update writes and load before the next is taken.
// After reset a clearing pass walks every page map entry and initializes the
// tables; no item is accepted meanwhile.
// A stalled result holds; the next item is accepted while it waits.
module two_level_page_table_lru import tlpt_pkg::*; #(
  parameter int PROCESS_COUNT = DEF_PROCESS_COUNT,
  parameter int FRAME_BITS = DEF_FRAME_BITS,
  parameter int VIRT_ADDR_BITS = DEF_VIRT_ADDR_BITS
) (
  input logic          clk,
  input logic          rst_n,
  tlpt_in_if.sink      in_ch,
  tlpt_out_if.source   out_ch,
  tlpt_cfg_if.sink     cfg_ch
);

  tlpt_cmd_t    cmd;
  tlpt_status_t status;

  assign cfg_ch.ready = 1'b1;

  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tlpt_datapath #(
    .PROCESS_COUNT  (PROCESS_COUNT),
    .FRAME_BITS     (FRAME_BITS),
    .VIRT_ADDR_BITS (VIRT_ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_ch.valid),
    .cfg_data     (cfg_ch.data),
    .in_pid       (in_ch.process_id),
    .in_va        (in_ch.virtual_address),
    .out_pa       (out_ch.physical_address),
    .out_hit      (out_ch.page_hit),
    .out_replaced (out_ch.frame_replaced),
    .out_created  (out_ch.level_one_created)
  );

endmodule

// File: tb/two_level_page_table_lru_test.sv
// Self-checking testbench of the two-level page table with LRU frame replacement.
`timescale 1ns / 1ps

module two_level_page_table_lru_test;
  import tlpt_pkg::*;

  localparam int FRAMES = 256;
  localparam int VPN_W = VA_W - OFFSET_W;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE = 320;
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            hit;
    logic            replaced;
    logic            created;
  } xlate_t;

  typedef struct {
    logic [PID_IN_W-1:0] pid;
    logic [VA_W-1:0]     va;
    bit                  typed;
    xlate_t              res;
  } access_row_t;

  logic clk;
  logic rst_n;
  int   errs;

  tlpt_in_if  in_ch ();
  tlpt_out_if out_ch ();
  tlpt_cfg_if cfg_ch ();

  two_level_page_table_lru u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow page table and LRU list
  bit [7:0]                map_frame[bit [PID_IN_W+VPN_W-1:0]];
  bit                      l1_seen[bit [PID_IN_W+VPN_W-1:0]];
  bit                      frame_busy[FRAMES];
  bit [PID_IN_W+VPN_W-1:0] frame_key[FRAMES];
  bit [7:0]                newer_of[FRAMES];
  bit [7:0]                older_of[FRAMES];
  bit [7:0]                lru_head;
  logic [CFG_W-1:0]        split_bits;
  xlate_t                  pending_xlates[$];
  logic [VPN_W-1:0]        page_pool[POOL_SIZE];

  // Move a frame to the newest end of the list
  task automatic promote_frame(input bit [7:0] f);
    bit [7:0] newest;
    bit [7:0] o;
    bit [7:0] n;
    newest = older_of[lru_head];
    if (f == lru_head) begin
      lru_head = newer_of[lru_head];
    end else if (f != newest) begin
      o = older_of[f];
      n = newer_of[f];
      newer_of[o] = n;
      older_of[n] = o;
      newer_of[f] = lru_head;
      older_of[f] = newest;
      newer_of[newest] = f;
      older_of[lru_head] = f;
    end
  endtask

  // Translate one access and update the shadow state
  task automatic translate(input logic [PID_IN_W-1:0] pid, input logic [VA_W-1:0] va,
                           output xlate_t r);
    logic [VPN_W-1:0]        vpn;
    int                      flb;
    logic [VPN_W-1:0]        l1;
    bit [PID_IN_W+VPN_W-1:0] key;
    bit [7:0]                f;
    vpn = va[VA_W-1:OFFSET_W];
    flb = (split_bits > VPN_W - 1) ? VPN_W - 1 : split_bits;
    l1 = (flb == 0) ? '0 : vpn >> (VPN_W - flb);
    r = '0;
    key = {pid, l1};
    if (!l1_seen.exists(key)) begin
      l1_seen[key] = 1'b1;
      r.created = 1'b1;
    end
    key = {pid, vpn};
    if (map_frame.exists(key)) begin
      f = map_frame[key];
      r.hit = 1'b1;
      promote_frame(f);
    end else begin
      f = lru_head;
      if (frame_busy[f]) begin
        map_frame.delete(frame_key[f]);
        r.replaced = 1'b1;
      end
      map_frame[key] = f;
      frame_busy[f] = 1'b1;
      frame_key[f] = key;
      lru_head = newer_of[f];
    end
    r.pa = {f, va[OFFSET_W-1:0]};
  endtask

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: clearing pass plus a generous margin for the items
  initial begin
    #250ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Random backpressure on the result side
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // Compare each result with the oldest expected translation
  always @(posedge clk) begin
    xlate_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_xlates.size() == 0) begin
        $error("result item with nothing expected");
        errs++;
      end else begin
        e = pending_xlates.pop_front();
        if (out_ch.physical_address !== e.pa) begin
          $error("physical_address expected %h got %h", e.pa, out_ch.physical_address);
          errs++;
        end
        if (out_ch.page_hit !== e.hit) begin
          $error("page_hit expected %b got %b", e.hit, out_ch.page_hit);
          errs++;
        end
        if (out_ch.frame_replaced !== e.replaced) begin
          $error("frame_replaced expected %b got %b", e.replaced, out_ch.frame_replaced);
          errs++;
        end
        if (out_ch.level_one_created !== e.created) begin
          $error("level_one_created expected %b got %b", e.created,
                 out_ch.level_one_created);
          errs++;
        end
      end
    end
  end

  // Offer one access and hold it until accepted
  task automatic send_access(input logic [PID_IN_W-1:0] pid, input logic [VA_W-1:0] va,
                             input bit typed, input xlate_t typed_res);
    int     g;
    xlate_t r;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.process_id <= pid;
    in_ch.virtual_address <= va;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    translate(pid, va, r);
    pending_xlates.push_back(typed ? typed_res : r);
  endtask

  // Drain, then write the split register
  task automatic write_split(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    split_bits = v;
  endtask

  // Random phase: mostly a recurring working set, some raw addresses
  task automatic random_phase(input int n);
    logic [VA_W-1:0] va;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80)
        va = {page_pool[$urandom_range(POOL_SIZE - 1)], 12'($urandom)};
      else
        va = $urandom;
      send_access(PID_IN_W'($urandom), va, 1'b0, '0);
    end
  endtask

  access_row_t directed[] = '{
    '{2'd0, 32'h0000_0000, 1'b1, '{20'h00000, 1'b0, 1'b0, 1'b1}},
    '{2'd0, 32'h0000_0FFF, 1'b1, '{20'h00FFF, 1'b1, 1'b0, 1'b0}},
    '{2'd3, 32'hFFFF_FFFF, 1'b1, '{20'h01FFF, 1'b0, 1'b0, 1'b1}},
    '{2'd1, 32'h0000_0000, 1'b1, '{20'h02000, 1'b0, 1'b0, 1'b1}},
    '{2'd2, 32'h8000_0ABC, 1'b1, '{20'h03ABC, 1'b0, 1'b0, 1'b1}},
    '{2'd0, 32'h0000_1000, 1'b0, '0},
    '{2'd0, 32'h0000_0800, 1'b0, '0},
    '{2'd3, 32'hFFFF_F000, 1'b0, '0},
    '{2'd3, 32'h7FFF_FFFF, 1'b0, '0},
    '{2'd2, 32'h5555_5555, 1'b0, '0},
    '{2'd1, 32'hAAAA_AAAA, 1'b0, '0},
    '{2'd0, 32'h0000_0001, 1'b0, '0},
    '{2'd2, 32'h8000_0000, 1'b0, '0},
    '{2'd1, 32'h0040_0000, 1'b0, '0},
    '{2'd0, 32'h0030_0000, 1'b0, '0}
  };

  initial begin
    errs = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.process_id = '0;
    in_ch.virtual_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    split_bits = FLB_RESET;
    for (int i = 0; i < FRAMES; i++) begin
      frame_busy[i] = 1'b0;
      newer_of[i] = 8'(i + 1);
      older_of[i] = 8'(i - 1);
    end
    lru_head = '0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = VPN_W'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset split
    foreach (directed[i])
      send_access(directed[i].pid, directed[i].va, directed[i].typed, directed[i].res);

    // Random phases at several splits, the extremes among them
    random_phase(RANDOM_ITEMS / 6);
    write_split(5'd0);
    random_phase(RANDOM_ITEMS / 6);
    write_split(5'd19);
    random_phase(RANDOM_ITEMS / 6);
    write_split(5'd31);
    random_phase(RANDOM_ITEMS / 6);
    write_split(5'd1);
    random_phase(RANDOM_ITEMS / 6);
    write_split(CFG_W'($urandom));
    random_phase(RANDOM_ITEMS / 6);

    // Drain the last results
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: two_level_page_table_lru.f
hw/rtl/tlpt_pkg.sv
hw/rtl/tlpt_ifs.sv
hw/rtl/tlpt_ctrl.sv
hw/rtl/tlpt_datapath.sv
hw/rtl/two_level_page_table_lru.sv
tb/two_level_page_table_lru_test.sv
